@@ rtl/acs_pkg.sv @@
// Shared types and constants for the ADC channel statistics unit.
package acs_pkg;

	typedef struct packed {
		logic        req_type;
		logic [7:0]  channel;
		logic [15:0] voltage_mv;
		logic        fault_flag;
		logic        out_of_range_flag;
	} acs_in_t;

	typedef struct packed {
		logic [5:0]  row_channel;
		logic [23:0] sample_count;
		logic [15:0] mean_mv;
		logic [15:0] rms_mv;
		logic [15:0] min_mv;
		logic [15:0] max_mv;
		logic [15:0] std_dev_mv;
		logic [23:0] over_count;
		logic [23:0] under_count;
		logic [23:0] faulty_count;
		logic [23:0] range_flag_count;
		logic        last;
	} acs_out_t;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_OVER_LIMIT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UNDER_LIMIT = 2'd1;

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_REPORT = 1'b1;

	localparam logic [15:0] OVER_LIMIT_RESET  = 16'd3000;
	localparam logic [15:0] UNDER_LIMIT_RESET = 16'd300;
	localparam logic [15:0] MIN_EMPTY         = 16'hFFFF;

	// Arithmetic steps of one report row, run in this order.
	localparam int OP_W = 3;
	localparam logic [OP_W-1:0] OP_MEAN    = 3'd0;
	localparam logic [OP_W-1:0] OP_MSQ     = 3'd1;
	localparam logic [OP_W-1:0] OP_RMS     = 3'd2;
	localparam logic [OP_W-1:0] OP_MUL_NSQ = 3'd3;
	localparam logic [OP_W-1:0] OP_MUL_SUM = 3'd4;
	localparam logic [OP_W-1:0] OP_SD_ROOT = 3'd5;
	localparam logic [OP_W-1:0] OP_SD      = 3'd6;
	localparam logic [OP_W-1:0] OP_FIRST   = OP_MEAN;
	localparam logic [OP_W-1:0] OP_LAST    = OP_SD;

	typedef struct packed {
		logic            capture;
		logic            rd_report;
		logic            wr_sample;
		logic            clr_entry;
		logic            idx_inc;
		logic            op_start;
		logic [OP_W-1:0] op;
		logic            out_load;
	} acs_cmd_t;

	typedef struct packed {
		logic is_report;
		logic in_range;
		logic op_done;
		logic idx_last;
		logic out_free;
	} acs_stat_t;

endpackage

@@ rtl/acs_seq_div.sv @@
// Restoring divider, one quotient bit per cycle.
module acs_seq_div #(
	parameter int N_W = 56,
	parameter int D_W = 24
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] dividend,
	input  logic [D_W-1:0] divisor,
	output logic [N_W-1:0] quotient,
	output logic           done
);
	localparam int CNT_W = $clog2(N_W + 1);

	logic [D_W:0]     rem_q;
	logic [N_W-1:0]   quo_q;
	logic [D_W-1:0]   dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [D_W:0]     rem_sh;
	logic             fits;

	assign rem_sh   = {rem_q[D_W-1:0], quo_q[N_W-1]};
	assign fits     = rem_sh >= {1'b0, dsr_q};
	assign quotient = quo_q;
	assign done     = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(N_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
			quo_q <= {quo_q[N_W-2:0], fits};
		end
	end

endmodule

@@ rtl/acs_isqrt.sv @@
// Digit-by-digit integer square root, one root bit per cycle.
module acs_isqrt #(
	parameter int R_W = 80
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [R_W-1:0]   radicand,
	output logic [R_W/2-1:0] root,
	output logic             done
);
	localparam int Q_W   = R_W / 2;
	localparam int CNT_W = $clog2(Q_W + 1);

	logic [Q_W+1:0]   rem_q;
	logic [Q_W-1:0]   root_q;
	logic [R_W-1:0]   rad_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [Q_W+1:0]   rem_n;
	logic [Q_W+1:0]   trial;
	logic             fits;

	assign rem_n = {rem_q[Q_W-1:0], rad_q[R_W-1:R_W-2]};
	assign trial = {root_q, 2'b01};
	assign fits  = rem_n >= trial;
	assign root  = root_q;
	assign done  = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(Q_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			root_q <= '0;
			rad_q  <= radicand;
		end else if (busy_q) begin
			rem_q  <= fits ? (rem_n - trial) : rem_n;
			root_q <= {root_q[Q_W-2:0], fits};
			rad_q  <= {rad_q[R_W-3:0], 2'b00};
		end
	end

endmodule

@@ rtl/acs_ctrl.sv @@
// Controller state machine: sample updates and the per-channel report sequence.
module acs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  acs_pkg::acs_stat_t stat,
	output acs_pkg::acs_cmd_t  cmd
);
	import acs_pkg::*;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_DISPATCH = 3'd1;
	localparam logic [2:0] S_READ     = 3'd2;
	localparam logic [2:0] S_LOAD     = 3'd3;
	localparam logic [2:0] S_OP       = 3'd4;
	localparam logic [2:0] S_OUT      = 3'd5;

	logic [2:0]      state_q, state_d;
	logic [OP_W-1:0] op_q, op_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		op_d     = op_q;
		in_ready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (stat.is_report) begin
					cmd.rd_report = 1'b1;
					state_d       = S_LOAD;
				end else begin
					cmd.wr_sample = stat.in_range;
					state_d       = S_IDLE;
				end
			end
			S_READ: begin
				cmd.rd_report = 1'b1;
				state_d       = S_LOAD;
			end
			S_LOAD: begin
				cmd.clr_entry = 1'b1;
				cmd.op_start  = 1'b1;
				cmd.op        = OP_FIRST;
				op_d          = OP_FIRST;
				state_d       = S_OP;
			end
			S_OP: begin
				if (stat.op_done) begin
					if (op_q == OP_LAST) begin
						state_d = S_OUT;
					end else begin
						op_d         = op_q + 3'd1;
						cmd.op_start = 1'b1;
						cmd.op       = op_d;
					end
				end
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					if (stat.idx_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = S_READ;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_FIRST;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
		end
	end

endmodule

@@ rtl/acs_dp.sv @@
// Datapath: channel state memory, sample update, divider, root, multiplier, output register.
module acs_dp #(
	parameter int CHANNEL_COUNT = 8,
	parameter int COUNT_BITS    = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  acs_pkg::acs_in_t                  in_data,
	input  logic                              cfg_we,
	input  logic [acs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [acs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  acs_pkg::acs_cmd_t                 cmd,
	output acs_pkg::acs_stat_t                stat,
	input  logic                              out_ready,
	output logic                              out_valid,
	output acs_pkg::acs_out_t                 out_data
);
	import acs_pkg::*;

	localparam int IDX_W     = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
	localparam int SUM_W     = COUNT_BITS + 16;
	localparam int SQ_W      = COUNT_BITS + 32;
	localparam int PROD_W    = 2 * COUNT_BITS + 32;
	localparam int ROOT_W    = PROD_W / 2;
	localparam int MUL_CNT_W = $clog2(SUM_W + 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] x,
		input logic hit);
		return (hit && x != COUNT_MAX) ? x + 1'b1 : x;
	endfunction

	logic [15:0] over_q, under_q;
	acs_in_t     item_q;
	logic [IDX_W-1:0] idx_q;
	logic [CHANNEL_COUNT-1:0] valid_q;

	logic [SUM_W-1:0]      mem_sum   [CHANNEL_COUNT];
	logic [SQ_W-1:0]       mem_sq    [CHANNEL_COUNT];
	logic [15:0]           mem_min   [CHANNEL_COUNT];
	logic [15:0]           mem_max   [CHANNEL_COUNT];
	logic [COUNT_BITS-1:0] mem_cnt   [CHANNEL_COUNT];
	logic [COUNT_BITS-1:0] mem_over  [CHANNEL_COUNT];
	logic [COUNT_BITS-1:0] mem_under [CHANNEL_COUNT];
	logic [COUNT_BITS-1:0] mem_fault [CHANNEL_COUNT];
	logic [COUNT_BITS-1:0] mem_oor   [CHANNEL_COUNT];

	logic [SUM_W-1:0]      rd_sum_q;
	logic [SQ_W-1:0]       rd_sq_q;
	logic [15:0]           rd_min_q, rd_max_q;
	logic [COUNT_BITS-1:0] rd_cnt_q, rd_over_q, rd_under_q, rd_fault_q, rd_oor_q;
	logic                  rd_vld_q;

	logic [IDX_W-1:0] rd_addr, wr_addr;

	// An entry never written since reset or its last report reads as empty.
	logic [SUM_W-1:0]      e_sum;
	logic [SQ_W-1:0]       e_sq;
	logic [15:0]           e_min, e_max;
	logic [COUNT_BITS-1:0] e_cnt, e_over, e_under, e_fault, e_oor;

	logic [15:0]      v;
	logic [31:0]      vsq;
	logic             not_sat;

	logic [OP_W-1:0]  cur_op_q;
	logic [15:0]      mean_q, rms_q, sd_q;
	logic [PROD_W-1:0] prod_a_q, diff;

	logic             div_start, sqrt_start, mul_start;
	logic [SQ_W-1:0]  div_dividend, div_quot;
	logic [PROD_W-1:0] sqrt_rad;
	logic [ROOT_W-1:0] sqrt_root;
	logic             div_done, sqrt_done;
	logic [PROD_W-1:0] mul_a_in;
	logic [SUM_W-1:0]  mul_b_in;

	logic [PROD_W-1:0] mul_acc_q, mul_a_q;
	logic [SUM_W-1:0]  mul_b_q;
	logic [MUL_CNT_W-1:0] mul_cnt_q;
	logic             mul_busy_q, mul_done_q;

	logic             out_valid_q;
	acs_out_t         out_q;
	logic             n_zero;

	assign rd_addr = cmd.capture ? in_data.channel[IDX_W-1:0] : idx_q;
	assign wr_addr = item_q.channel[IDX_W-1:0];

	assign e_sum   = rd_vld_q ? rd_sum_q   : '0;
	assign e_sq    = rd_vld_q ? rd_sq_q    : '0;
	assign e_min   = rd_vld_q ? rd_min_q   : MIN_EMPTY;
	assign e_max   = rd_vld_q ? rd_max_q   : '0;
	assign e_cnt   = rd_vld_q ? rd_cnt_q   : '0;
	assign e_over  = rd_vld_q ? rd_over_q  : '0;
	assign e_under = rd_vld_q ? rd_under_q : '0;
	assign e_fault = rd_vld_q ? rd_fault_q : '0;
	assign e_oor   = rd_vld_q ? rd_oor_q   : '0;

	assign v       = item_q.voltage_mv;
	assign vsq     = {16'b0, v} * {16'b0, v};
	assign not_sat = (e_cnt != COUNT_MAX);

	assign stat.is_report = (item_q.req_type == REQ_REPORT);
	assign stat.in_range  = ({1'b0, item_q.channel} < 9'(CHANNEL_COUNT));
	assign stat.op_done   = div_done | sqrt_done | mul_done_q;
	assign stat.idx_last  = (idx_q == IDX_W'(CHANNEL_COUNT - 1));
	assign stat.out_free  = !out_valid_q || out_ready;

	// A step that uses the previous step's result starts in that step's done cycle,
	// so it takes the value straight from the unit, which holds it until restarted.
	assign diff = (prod_a_q > mul_acc_q) ? (prod_a_q - mul_acc_q) : '0;

	always_comb begin
		div_start    = 1'b0;
		sqrt_start   = 1'b0;
		mul_start    = 1'b0;
		div_dividend = SQ_W'(e_sum);
		sqrt_rad     = PROD_W'(div_quot);
		mul_a_in     = PROD_W'(e_sq);
		mul_b_in     = SUM_W'(e_cnt);
		if (cmd.op_start) begin
			case (cmd.op)
				OP_MEAN: begin
					div_start    = 1'b1;
					div_dividend = SQ_W'(e_sum);
				end
				OP_MSQ: begin
					div_start    = 1'b1;
					div_dividend = e_sq;
				end
				OP_RMS: begin
					sqrt_start = 1'b1;
					sqrt_rad   = PROD_W'(div_quot);
				end
				OP_MUL_NSQ: begin
					mul_start = 1'b1;
					mul_a_in  = PROD_W'(e_sq);
					mul_b_in  = SUM_W'(e_cnt);
				end
				OP_MUL_SUM: begin
					mul_start = 1'b1;
					mul_a_in  = PROD_W'(e_sum);
					mul_b_in  = e_sum;
				end
				OP_SD_ROOT: begin
					sqrt_start = 1'b1;
					sqrt_rad   = diff;
				end
				OP_SD: begin
					div_start    = 1'b1;
					div_dividend = SQ_W'(sqrt_root);
				end
				default: begin
				end
			endcase
		end
	end

	acs_seq_div #(
		.N_W(SQ_W),
		.D_W(COUNT_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (e_cnt),
		.quotient (div_quot),
		.done     (div_done)
	);

	acs_isqrt #(
		.R_W(PROD_W)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (sqrt_rad),
		.root     (sqrt_root),
		.done     (sqrt_done)
	);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			over_q      <= OVER_LIMIT_RESET;
			under_q     <= UNDER_LIMIT_RESET;
			idx_q       <= '0;
			valid_q     <= '0;
			cur_op_q    <= OP_FIRST;
			mul_busy_q  <= 1'b0;
			mul_done_q  <= 1'b0;
			mul_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_OVER_LIMIT:  over_q  <= cfg_wdata;
					REG_UNDER_LIMIT: under_q <= cfg_wdata;
					default: begin
					end
				endcase
			end
			if (cmd.capture) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.wr_sample) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (cmd.clr_entry) begin
				valid_q[idx_q] <= 1'b0;
			end
			if (cmd.op_start) begin
				cur_op_q <= cmd.op;
			end
			mul_done_q <= 1'b0;
			if (mul_start) begin
				mul_busy_q <= 1'b1;
				mul_cnt_q  <= '0;
			end else if (mul_busy_q) begin
				mul_cnt_q <= mul_cnt_q + 1'b1;
				if (mul_cnt_q == MUL_CNT_W'(SUM_W - 1)) begin
					mul_busy_q <= 1'b0;
					mul_done_q <= 1'b1;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Channel memory: read on capture or report step; a sample is written back in the cycle after its read.
	always_ff @(posedge clk) begin
		if (cmd.capture || cmd.rd_report) begin
			rd_sum_q   <= mem_sum[rd_addr];
			rd_sq_q    <= mem_sq[rd_addr];
			rd_min_q   <= mem_min[rd_addr];
			rd_max_q   <= mem_max[rd_addr];
			rd_cnt_q   <= mem_cnt[rd_addr];
			rd_over_q  <= mem_over[rd_addr];
			rd_under_q <= mem_under[rd_addr];
			rd_fault_q <= mem_fault[rd_addr];
			rd_oor_q   <= mem_oor[rd_addr];
			rd_vld_q   <= valid_q[rd_addr];
		end
		if (cmd.wr_sample) begin
			mem_cnt[wr_addr]   <= not_sat ? e_cnt + 1'b1 : e_cnt;
			mem_sum[wr_addr]   <= not_sat ? e_sum + SUM_W'(v) : e_sum;
			mem_sq[wr_addr]    <= not_sat ? e_sq + SQ_W'(vsq) : e_sq;
			mem_min[wr_addr]   <= (v < e_min) ? v : e_min;
			mem_max[wr_addr]   <= (v > e_max) ? v : e_max;
			mem_over[wr_addr]  <= sat_inc(e_over, v > over_q);
			mem_under[wr_addr] <= sat_inc(e_under, v < under_q);
			mem_fault[wr_addr] <= sat_inc(e_fault, item_q.fault_flag);
			mem_oor[wr_addr]   <= sat_inc(e_oor, item_q.out_of_range_flag);
		end
	end

	// Item capture, shift-add multiplier and arithmetic results.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_data;
		end
		if (mul_start) begin
			mul_acc_q <= '0;
			mul_a_q   <= mul_a_in;
			mul_b_q   <= mul_b_in;
		end else if (mul_busy_q) begin
			if (mul_b_q[0]) begin
				mul_acc_q <= mul_acc_q + mul_a_q;
			end
			mul_a_q <= {mul_a_q[PROD_W-2:0], 1'b0};
			mul_b_q <= {1'b0, mul_b_q[SUM_W-1:1]};
		end
		if (div_done) begin
			case (cur_op_q)
				OP_MEAN: mean_q <= div_quot[15:0];
				OP_SD:   sd_q   <= div_quot[15:0];
				default: begin
				end
			endcase
		end
		if (sqrt_done) begin
			case (cur_op_q)
				OP_RMS:  rms_q <= sqrt_root[15:0];
				default: begin
				end
			endcase
		end
		if (mul_done_q) begin
			case (cur_op_q)
				OP_MUL_NSQ: prod_a_q <= mul_acc_q;
				default: begin
				end
			endcase
		end
	end

	// The quotient and root results are meaningless for an empty channel.
	assign n_zero = (e_cnt == '0);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.row_channel      <= 6'(idx_q);
			out_q.sample_count     <= 24'(e_cnt);
			out_q.mean_mv          <= n_zero ? 16'd0 : mean_q;
			out_q.rms_mv           <= n_zero ? 16'd0 : rms_q;
			out_q.min_mv           <= e_min;
			out_q.max_mv           <= e_max;
			out_q.std_dev_mv       <= n_zero ? 16'd0 : sd_q;
			out_q.over_count       <= 24'(e_over);
			out_q.under_count      <= 24'(e_under);
			out_q.faulty_count     <= 24'(e_fault);
			out_q.range_flag_count <= 24'(e_oor);
			out_q.last             <= stat.idx_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ rtl/adc_channel_statistics_unit.sv @@
// Top level of the ADC channel statistics unit: controller, datapath and checks.
//
//  channel | direction | beat carries                 | handshake
//  in      | input     | one sample or report request | in_valid / in_ready
//  out     | output    | one channel row of a report  | out_valid / out_ready
//  cfg     | input     | one limit register write     | cfg_we
//
// A sample beat is a read of the channel entry, then the write-back if the channel is in range.
// A report walks every channel in turn; each row's time, with a free output, is set by the
// bit-serial divider (three passes), root unit and multiplier (two each).
// Reset clears the limits to their defaults and marks every channel entry empty.
// A stalled output row holds the next row's completion; the input waits only on the controller.
module adc_channel_statistics_unit #(
	parameter int CHANNEL_COUNT = 8,
	parameter int COUNT_BITS    = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  acs_pkg::acs_in_t               in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output acs_pkg::acs_out_t              out_data,
	input  logic                           cfg_we,
	input  logic [acs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [acs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import acs_pkg::*;

	acs_cmd_t  cmd;
	acs_stat_t stat;

	acs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	acs_dp #(
		.CHANNEL_COUNT (CHANNEL_COUNT),
		.COUNT_BITS    (COUNT_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

	// Each accepted beat is decoded before another one can be taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted on two consecutive cycles");

	// Arithmetic completions only happen inside a report.
	assert property (@(posedge clk) disable iff (!arst_n)
		stat.op_done |-> !in_ready)
		else $error("arithmetic unit finished while the controller was idle");

	// A row is never loaded over one that is still waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || out_ready))
		else $error("output row overwritten before it was taken");

endmodule
